### rtl/vpp_pkg.sv
// Package with the shared constants of the vertex perspective projection block.
`timescale 1ns / 1ps
`default_nettype none
package vpp_pkg;

  localparam int FracBitsDefault = 16;
  localparam int ScreenWDefault  = 396;
  localparam int ScreenHDefault  = 224;
  localparam int FovUnits        = 300;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegCamPosX   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegCamPosY   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCamPosZ   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRotX      = 4'd3;
  localparam logic [CfgIdxW-1:0] RegRotY      = 4'd4;
  localparam logic [CfgIdxW-1:0] RegRotZ      = 4'd5;
  localparam logic [CfgIdxW-1:0] RegScrShiftX = 4'd6;
  localparam logic [CfgIdxW-1:0] RegScrShiftY = 4'd7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] p3;
  } prod_t;

endpackage
`default_nettype wire

### rtl/vertex_perspective_projection.sv
// Pipelined fixed-point perspective projection of one vertex per beat.
// Stage order: convert, rotate, divide, scale, output register.
// Throughput: one beat per cycle; the whole pipe holds while the output beat is stalled.
// The divider is one restoring step per stage, FRAC_BITS + 9 stages, and sets the depth.
// Reset clears all stage valid bits and loads the configuration reset values.
`timescale 1ns / 1ps
`default_nettype none
module vertex_perspective_projection #(
  parameter int FRAC_BITS = vpp_pkg::FracBitsDefault,
  parameter int SCREEN_W  = vpp_pkg::ScreenWDefault,
  parameter int SCREEN_H  = vpp_pkg::ScreenHDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [vpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [vpp_pkg::CfgDataW-1:0] cfg_data_i,
  // Vertex input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [15:0]           vert_x_i,
  input  wire logic signed [15:0]           vert_y_i,
  input  wire logic signed [15:0]           vert_z_i,
  input  wire logic signed [31:0]           shift_x_i,
  input  wire logic signed [31:0]           shift_y_i,
  input  wire logic signed [31:0]           shift_z_i,
  // Projected point output channel.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [31:0]                proj_x_o,
  output logic signed [31:0]                proj_y_o,
  output logic signed [31:0]                proj_depth_o
);

  // Quotient bits: 300 << 2F divided by a depth of at least 1.0 stays below 2^(F+9).
  localparam int          QW       = FRAC_BITS + 9;
  localparam logic [63:0] NUM      = 64'(vpp_pkg::FovUnits) << (2 * FRAC_BITS);
  // The numerator bits above the quotient form a start remainder below 1.0.
  localparam logic [31:0] REM_INIT = 32'(NUM >> QW);
  localparam logic [31:0] ONE_FX   = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] HALF_W   = 32'(64'(SCREEN_W / 2) << FRAC_BITS);
  localparam logic [31:0] HALF_H   = 32'(64'(SCREEN_H / 2) << FRAC_BITS);
  localparam logic [63:0] ROT_RST  = {ONE_FX, 32'd0};

  // Q-format product: full 64-bit product, arithmetic shift, low 32 bits kept.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'(p >>> FRAC_BITS);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; indexes past the list
  // are dropped.
  // ---------------------------------------------------------------------------
  logic signed [15:0] cam_x_q, cam_y_q, cam_z_q, scr_x_q, scr_y_q;
  logic [63:0]        rot_x_q, rot_y_q, rot_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      scr_x_q <= '0;
      scr_y_q <= '0;
      rot_x_q <= ROT_RST;
      rot_y_q <= ROT_RST;
      rot_z_q <= ROT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vpp_pkg::RegCamPosX:   cam_x_q <= cfg_data_i[15:0];
        vpp_pkg::RegCamPosY:   cam_y_q <= cfg_data_i[15:0];
        vpp_pkg::RegCamPosZ:   cam_z_q <= cfg_data_i[15:0];
        vpp_pkg::RegRotX:      rot_x_q <= cfg_data_i;
        vpp_pkg::RegRotY:      rot_y_q <= cfg_data_i;
        vpp_pkg::RegRotZ:      rot_z_q <= cfg_data_i;
        vpp_pkg::RegScrShiftX: scr_x_q <= cfg_data_i[15:0];
        vpp_pkg::RegScrShiftY: scr_y_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] cxc, cxs, cyc, cys, czc, czs;
  assign cxc = rot_x_q[63:32];
  assign cxs = rot_x_q[31:0];
  assign cyc = rot_y_q[63:32];
  assign cys = rot_y_q[31:0];
  assign czc = rot_z_q[63:32];
  assign czs = rot_z_q[31:0];

  // ---------------------------------------------------------------------------
  // Global pipe enable: every stage moves unless a finished beat sits stalled
  // at the output register.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 0: convert to fixed point, add translation, subtract camera.
  vpp_pkg::vec_t  s0_d, s0_q;
  logic           v0_q;
  always_comb begin
    s0_d.x = (32'(vert_x_i) << FRAC_BITS) + shift_x_i - (32'(cam_x_q) << FRAC_BITS);
    s0_d.y = (32'(vert_y_i) << FRAC_BITS) + shift_y_i - (32'(cam_y_q) << FRAC_BITS);
    s0_d.z = (32'(vert_z_i) << FRAC_BITS) + shift_z_i - (32'(cam_z_q) << FRAC_BITS);
  end

  // Stages 1/2: rotation about X (y, z). Stages 3/4: about Y (x, z).
  // Stages 5/6: about Z (x, y). Each is a product stage then a sum stage.
  vpp_pkg::prod_t m1_d, m1_q, m3_d, m3_q, m5_d, m5_q;
  vpp_pkg::vec_t  c1_q, c3_q, c5_q;
  vpp_pkg::vec_t  s2_d, s2_q, s4_d, s4_q, s6_d, s6_q;
  logic           v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  always_comb begin
    m1_d.p0 = fx_mul(s0_q.y, cxc);
    m1_d.p1 = fx_mul(s0_q.z, cxs);
    m1_d.p2 = fx_mul(s0_q.y, cxs);
    m1_d.p3 = fx_mul(s0_q.z, cxc);
    s2_d.x  = c1_q.x;
    s2_d.y  = m1_q.p0 - m1_q.p1;
    s2_d.z  = m1_q.p2 + m1_q.p3;

    m3_d.p0 = fx_mul(s2_q.x, cyc);
    m3_d.p1 = fx_mul(s2_q.z, cys);
    m3_d.p2 = fx_mul(-s2_q.x, cys);
    m3_d.p3 = fx_mul(s2_q.z, cyc);
    s4_d.x  = m3_q.p0 + m3_q.p1;
    s4_d.y  = c3_q.y;
    s4_d.z  = m3_q.p2 + m3_q.p3;

    m5_d.p0 = fx_mul(s4_q.x, czc);
    m5_d.p1 = fx_mul(s4_q.y, czs);
    m5_d.p2 = fx_mul(s4_q.x, czs);
    m5_d.p3 = fx_mul(s4_q.y, czc);
    s6_d.x  = m5_q.p0 - m5_q.p1;
    s6_d.y  = m5_q.p2 + m5_q.p3;
    s6_d.z  = c5_q.z;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
      m1_q <= m1_d;
      c1_q <= s0_q;
      s2_q <= s2_d;
      m3_q <= m3_d;
      c3_q <= s2_q;
      s4_q <= s4_d;
      m5_q <= m5_d;
      c5_q <= s4_q;
      s6_q <= s6_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: scale = (300 << 2F) / max(depth, 1.0), one restoring step per
  // stage. The numerator is constant, so each stage shifts in a fixed bit.
  // ---------------------------------------------------------------------------
  logic        [31:0] dv_r_q [QW];
  logic        [QW-1:0] dv_f_q [QW];
  logic        [31:0] dv_d_q [QW];
  vpp_pkg::vec_t      dv_v_q [QW];
  logic        [QW-1:0] dv_ok_q;

  logic [31:0] clamp_d;
  assign clamp_d = (s6_q.z < $signed(ONE_FX)) ? ONE_FX : s6_q.z;

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [31:0]   r_in, d_in, r_d;
    logic [QW-1:0] f_in, f_d;
    vpp_pkg::vec_t v_in;
    logic          ok_in;
    logic [32:0]   rs, diff;

    if (k == 0) begin : g_first
      assign r_in  = REM_INIT;
      assign f_in  = '0;
      assign d_in  = clamp_d;
      assign v_in  = s6_q;
      assign ok_in = v6_q;
    end else begin : g_next
      assign r_in  = dv_r_q[k-1];
      assign f_in  = dv_f_q[k-1];
      assign d_in  = dv_d_q[k-1];
      assign v_in  = dv_v_q[k-1];
      assign ok_in = dv_ok_q[k-1];
    end

    always_comb begin
      rs   = {r_in, NUM[QW-1-k]};
      diff = rs - {1'b0, d_in};
      if (!diff[32]) begin
        r_d = diff[31:0];
        f_d = {f_in[QW-2:0], 1'b1};
      end else begin
        r_d = rs[31:0];
        f_d = {f_in[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_r_q[k] <= r_d;
        dv_f_q[k] <= f_d;
        dv_d_q[k] <= d_in;
        dv_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_ok_q[k] <= 1'b0;
      end else if (adv) begin
        dv_ok_q[k] <= ok_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scale stage, then the output register with the screen centre and offset.
  // ---------------------------------------------------------------------------
  logic signed [31:0] scale;
  logic signed [31:0] px_p_q, py_p_q, pz_q;
  logic               vp_q;
  logic signed [31:0] proj_x_q, proj_y_q, proj_z_q;

  assign scale = 32'(dv_f_q[QW-1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_p_q   <= fx_mul(dv_v_q[QW-1].x, scale);
      py_p_q   <= fx_mul(-dv_v_q[QW-1].y, scale);
      pz_q     <= dv_v_q[QW-1].z;
      proj_x_q <= px_p_q + HALF_W + (32'(scr_x_q) << FRAC_BITS);
      proj_y_q <= py_p_q + HALF_H + (32'(scr_y_q) << FRAC_BITS);
      proj_z_q <= pz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vp_q        <= dv_ok_q[QW-1];
      out_valid_q <= vp_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign proj_x_o     = proj_x_q;
  assign proj_y_o     = proj_y_q;
  assign proj_depth_o = proj_z_q;

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the vertex perspective projection pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int Frac    = vpp_pkg::FracBitsDefault;
  localparam int Latency = Frac + 18;

  // A projected point as the block should deliver it.
  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] depth;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [vpp_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [vpp_pkg::CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [15:0] vert_x_i, vert_y_i, vert_z_i;
  logic signed [31:0] shift_x_i, shift_y_i, shift_z_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] proj_x_o, proj_y_o, proj_depth_o;

  vertex_perspective_projection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vert_x_i    (vert_x_i),
    .vert_y_i    (vert_y_i),
    .vert_z_i    (vert_z_i),
    .shift_x_i   (shift_x_i),
    .shift_y_i   (shift_y_i),
    .shift_z_i   (shift_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .proj_x_o    (proj_x_o),
    .proj_y_o    (proj_y_o),
    .proj_depth_o(proj_depth_o)
  );

  // Mirror of the camera and viewport registers, kept in step with every
  // configuration write.
  logic [31:0] cam_x, cam_y, cam_z;
  logic [63:0] rot_x, rot_y, rot_z;
  logic [31:0] scr_x, scr_y;

  point_t expected_points[$];
  int     error_count;
  bit     hold_receiver;   // forces a long output stall while set
  bit     quiet_receiver;  // disables random output stalls

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Fixed-point product: full signed product, arithmetic shift, low word kept.
  function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] prod;
    prod = 64'($signed(a)) * 64'($signed(b));
    return 32'(prod >>> Frac);
  endfunction

  function automatic point_t project_vertex(logic [15:0] vx, logic [15:0] vy,
                                            logic [15:0] vz, logic [31:0] sx,
                                            logic [31:0] sy, logic [31:0] sz);
    logic [31:0] x, y, z, nx, ny, nz, c, s, dz, f;
    logic signed [63:0] num, q;
    point_t pt;
    x = (32'($signed(vx)) << Frac) + sx - (cam_x << Frac);
    y = (32'($signed(vy)) << Frac) + sy - (cam_y << Frac);
    z = (32'($signed(vz)) << Frac) + sz - (cam_z << Frac);
    // Rotate about X (y, z).
    c = rot_x[63:32]; s = rot_x[31:0];
    ny = fx_mul(y, c) - fx_mul(z, s);
    nz = fx_mul(y, s) + fx_mul(z, c);
    y = ny; z = nz;
    // Rotate about Y (x, z); the sine sign sits on the other term here.
    c = rot_y[63:32]; s = rot_y[31:0];
    nx = fx_mul(x, c) + fx_mul(z, s);
    nz = fx_mul(-x, s) + fx_mul(z, c);
    x = nx; z = nz;
    // Rotate about Z (x, y).
    c = rot_z[63:32]; s = rot_z[31:0];
    nx = fx_mul(x, c) - fx_mul(y, s);
    ny = fx_mul(x, s) + fx_mul(y, c);
    x = nx; y = ny;
    // Points behind or too near the camera are projected at depth 1.0.
    dz = ($signed(z) < $signed(32'(1) << Frac)) ? (32'(1) << Frac) : z;
    num = 64'(vpp_pkg::FovUnits) << (2 * Frac);
    q = num / 64'($signed(dz));
    f = 32'(q);
    pt.px = fx_mul(x, f) + (32'(vpp_pkg::ScreenWDefault / 2) << Frac) + (scr_x << Frac);
    pt.py = fx_mul(-y, f) + (32'(vpp_pkg::ScreenHDefault / 2) << Frac) + (scr_y << Frac);
    pt.depth = z;
    return pt;
  endfunction

  // Short gaps are the norm, with an occasional long one.
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output stall generator. Each beat is checked against the oldest prediction.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected beat: x=%h y=%h depth=%h", proj_x_o, proj_y_o, proj_depth_o);
          error_count++;
        end else begin
          point_t exp_pt;
          exp_pt = expected_points.pop_front();
          if (proj_x_o !== exp_pt.px) begin
            $error("proj_x: expected %h, got %h", exp_pt.px, proj_x_o);
            error_count++;
          end
          if (proj_y_o !== exp_pt.py) begin
            $error("proj_y: expected %h, got %h", exp_pt.py, proj_y_o);
            error_count++;
          end
          if (proj_depth_o !== exp_pt.depth) begin
            $error("proj_depth: expected %h, got %h", exp_pt.depth, proj_depth_o);
            error_count++;
          end
        end
      end
      if (hold_receiver) begin
        out_stall_i <= 1'b1;
      end else if (quiet_receiver) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_left  <= random_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_register(logic [vpp_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      vpp_pkg::RegCamPosX:   cam_x = 32'($signed(value[15:0]));
      vpp_pkg::RegCamPosY:   cam_y = 32'($signed(value[15:0]));
      vpp_pkg::RegCamPosZ:   cam_z = 32'($signed(value[15:0]));
      vpp_pkg::RegRotX:      rot_x = value;
      vpp_pkg::RegRotY:      rot_y = value;
      vpp_pkg::RegRotZ:      rot_z = value;
      vpp_pkg::RegScrShiftX: scr_x = 32'($signed(value[15:0]));
      vpp_pkg::RegScrShiftY: scr_y = 32'($signed(value[15:0]));
      default: ;
    endcase
  endtask

  // Sends one vertex beat; the prediction is queued at the accepting edge.
  // Every caller arrives here at a rising edge.
  task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : random_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vert_x_i   <= vx;
    vert_y_i   <= vy;
    vert_z_i   <= vz;
    shift_x_i  <= sx;
    shift_y_i  <= sy;
    shift_z_i  <= sz;
    do @(posedge clk_i); while (in_stall_o);
    expected_points.push_back(project_vertex(vx, vy, vz, sx, sy, sz));
    // Valid stays high here; the next send either moves on or drops it.
  endtask

  // Drops valid at the accepting edge itself so that no beat is taken twice.
  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every predicted beat has arrived, plus the pipe depth so
  // that the block is idle before the next register write.
  task automatic drain();
    drop_valid();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_shift();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) << Frac;
      2: return $urandom_range(0, 32'hFFFF);
      default: return (32'($urandom_range(0, 200)) << Frac) | $urandom_range(0, 32'hFFFF);
    endcase
  endfunction

  function automatic logic [15:0] rand_vert();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 400)) - 200);
  endfunction

  // A cosine/sine pair with each term in [-1.0, 1.0] most of the time, raw bits otherwise.
  function automatic logic [63:0] rand_rotation();
    logic [31:0] c, s;
    if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
    c = 32'($signed($urandom_range(0, 131072)) - 65536);
    s = 32'($signed($urandom_range(0, 131072)) - 65536);
    return {c, s};
  endfunction

  task automatic test_default_extremes();
    send_vertex(16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_vertex(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    // Depth exactly 1.0, just under it, negative, and a far one whose sum wraps negative.
    send_vertex(16'd10, -16'sd10, 16'd1, 0, 0, 0);
    send_vertex(16'd10, 16'd10, 16'd0, 0, 0, 32'h0000FFFF);
    send_vertex(16'd5, 16'd5, -16'sd50, 0, 0, 0);
    send_vertex(16'd100, 16'd100, 16'd30000, 0, 0, 32'h7FFF0000);
    // A most negative y so that the negation wraps to itself.
    send_vertex(16'd0, 16'h8000, 16'd3, 0, 0, 0);
    send_vertex(16'h5555, 16'hAAAA, 16'h5555, 32'hAAAAAAAA, 32'h55555555, 32'h0001AAAA);
    send_vertex(16'hAAAA, 16'h5555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h00015555);
    drain();
  endtask

  task automatic test_register_extremes();
    write_register(vpp_pkg::RegCamPosX, 64'h7FFF);
    write_register(vpp_pkg::RegCamPosY, 64'hFFFF_FFFF_FFFF_8000);
    write_register(vpp_pkg::RegCamPosZ, 64'h8000);
    write_register(vpp_pkg::RegRotX, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(vpp_pkg::RegRotY, 64'h8000_0000_7FFF_FFFF);
    write_register(vpp_pkg::RegRotZ, 64'h0000_0000_0001_0000);
    write_register(vpp_pkg::RegScrShiftX, 64'h8000);
    write_register(vpp_pkg::RegScrShiftY, 64'h7FFF);
    repeat (6) send_vertex(rand_vert(), rand_vert(), rand_vert(),
                           rand_shift(), rand_shift(), rand_shift());
    drain();
    // Quarter turns about X and Z, a half turn about Y, camera pulled back.
    write_register(vpp_pkg::RegCamPosX, 64'd0);
    write_register(vpp_pkg::RegCamPosY, 64'd0);
    write_register(vpp_pkg::RegCamPosZ, -64'sd100);
    write_register(vpp_pkg::RegRotX, {32'd0, 32'h0001_0000});
    write_register(vpp_pkg::RegRotY, {32'hFFFF_0000, 32'd0});
    write_register(vpp_pkg::RegRotZ, {32'd0, 32'hFFFF_0000});
    write_register(vpp_pkg::RegScrShiftX, 64'd0);
    write_register(vpp_pkg::RegScrShiftY, 64'd0);
    repeat (6) send_vertex(rand_vert(), rand_vert(), rand_vert(),
                           rand_shift(), rand_shift(), rand_shift());
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      write_register(vpp_pkg::RegCamPosX, 64'($signed($urandom_range(0, 200)) - 100));
      write_register(vpp_pkg::RegCamPosY, 64'($signed($urandom_range(0, 200)) - 100));
      write_register(vpp_pkg::RegCamPosZ, {48'($urandom()), 16'($urandom())});
      write_register(vpp_pkg::RegRotX, rand_rotation());
      write_register(vpp_pkg::RegRotY, rand_rotation());
      write_register(vpp_pkg::RegRotZ, rand_rotation());
      write_register(vpp_pkg::RegScrShiftX, 64'($urandom()));
      write_register(vpp_pkg::RegScrShiftY, 64'($urandom()));
      repeat (100) send_vertex(rand_vert(), rand_vert(), rand_vert(),
                               rand_shift(), rand_shift(), rand_shift());
      drain();
    end
  endtask

  // The receiver holds off while beats keep coming, so the pipe fills and
  // the input stall must rise; then the sender waits for a full drain.
  task automatic test_backpressure();
    int held_cycles;
    quiet_receiver = 1;
    hold_receiver  = 1;
    fork
      begin
        held_cycles = 0;
        while (held_cycles < 3 * Latency) begin
          @(posedge clk_i);
          held_cycles++;
        end
        hold_receiver = 0;
      end
      repeat (80) send_vertex(rand_vert(), rand_vert(), rand_vert(),
                              rand_shift(), rand_shift(), rand_shift(), 1);
    join
    drop_valid();
    while (expected_points.size() != 0) @(posedge clk_i);
    quiet_receiver = 0;
    repeat (40) send_vertex(rand_vert(), rand_vert(), rand_vert(),
                            rand_shift(), rand_shift(), rand_shift());
    drain();
  endtask

  initial begin
    error_count    = 0;
    hold_receiver  = 0;
    quiet_receiver = 0;
    cam_x = 0; cam_y = 0; cam_z = 0;
    rot_x = 64'(1) << (32 + Frac);
    rot_y = 64'(1) << (32 + Frac);
    rot_z = 64'(1) << (32 + Frac);
    scr_x = 0; scr_y = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    vert_x_i    = '0;
    vert_y_i    = '0;
    vert_z_i    = '0;
    shift_x_i   = '0;
    shift_y_i   = '0;
    shift_z_i   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_extremes();
    test_register_extremes();
    test_backpressure();
    test_random_settings();
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Generous ceiling: 743 beats in all, with random gaps and stalls.
  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

endmodule
`default_nettype wire

### vertex_perspective_projection.f
rtl/vpp_pkg.sv
rtl/vertex_perspective_projection.sv
verif/tb.sv
